// ===== sv/periodic_task_timer_table_macros.svh =====
// Assertion macros for the periodic task timer table.
// Used by the top level only; no other dependencies.
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`ifndef SYNTH
`define PTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PTT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PTT_ASSERT_IMP(label, clk, rst, ante, cons)
`define PTT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ptt_pkg.sv =====
// Shared types and codes for the periodic task timer table.
// No dependencies.
`default_nettype none
package ptt_pkg;
   localparam int SLOTS_DEF = 16;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_IVL_RESET = 32'd10;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_DEL  = 3'd1;
   localparam logic [2:0] OP_SUSP = 3'd2;
   localparam logic [2:0] OP_RES  = 3'd3;
   localparam logic [2:0] OP_TICK = 3'd4;

   localparam logic [2:0] KIND_ADDED  = 3'd0;
   localparam logic [2:0] KIND_FIRED  = 3'd1;
   localparam logic [2:0] KIND_TICK   = 3'd2;
   localparam logic [2:0] KIND_OPDONE = 3'd3;
   localparam logic [2:0] KIND_FULL   = 3'd4;

   typedef struct packed {
      logic        valid;
      logic        fired;
      logic        susp;
      logic [31:0] id;
      logic [31:0] ivl;
      logic [31:0] exp;
      logic [31:0] rem;
   } slot_type;
endpackage
`default_nettype wire

// ===== sv/periodic_task_timer_table.sv =====
// Periodic task timer table: SLOTS timer slots held in a rotating row of cells.
// Add, delete, suspend, resume and tick take one full rotation of the row, then a
// response step; a tick that fires entries adds a rotation and a fire step for
// each fired entry, since each fired id is picked by a further rotation that
// finds the largest remaining id. Every slot passes the single processing point at
// the head cell once per rotation. Opcodes 5 to 7 skip the rotation and answer with
// a response only. The fire and response steps wait while the output is stalled.
// Depends on ptt_pkg, ptt_cell and periodic_task_timer_table_macros.svh.
`default_nettype none
`include "periodic_task_timer_table_macros.svh"
module periodic_task_timer_table #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] entry_id, [63:32] interval, [95:64] repeat_count,
   // [96] start_suspended, [128:97] now, [135:129] zero
   input  wire logic [135:0] req_tdata,
   // [2:0] opcode
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] result_id, [63:32] wait_time
   output logic [63:0]       rsp_tdata,
   // [2:0] kind
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);
   import ptt_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(SLOTS - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_SORT, ST_FIRE, ST_RESP} state_type;

   state_type     state_ff;
   logic [IW-1:0] step_ff;
   logic [2:0]    op_ff;
   logic [31:0]   eid_ff, ivl_ff, rep_ff, now_ff, minexp_ff, min_ivl_ff, last_id_ff;
   logic          susp_ff, found_ff, best_ff, clr_ff;
   logic [CW-1:0] nf_ff;
   logic [31:0]   best_id_ff;
   logic [IW-1:0] best_idx_ff, clr_idx_ff;
   logic [2:0]    res_kind_ff;
   logic [31:0]   res_id_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [2:0]    rsp_kind_ff;
   logic [31:0]   rsp_id_ff, rsp_wait_ff;

   slot_type cell_q [SLOTS];
   slot_type cell_d [SLOTS];
   slot_type head, proc;
   logic     shift, due, match, sort_fired, proc_hit, min_take, sort_take, out_free;
   logic     rsp_load;
   logic [31:0] eff_min;
   logic [CW-1:0] nf_in;

   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_SORT);
   assign head  = cell_q[0];

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         if (g == SLOTS - 1) begin : g_tail
            assign cell_d[g] = proc;
         end else begin : g_mid
            assign cell_d[g] = cell_q[g+1];
         end
         ptt_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     (cell_d[g]),
            .q     (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      proc       = head;
      proc_hit   = 1'b0;
      due        = head.valid && !head.susp && (now_ff >= head.exp);
      match      = head.valid && (head.id == eid_ff) && !found_ff;
      sort_fired = head.fired && !(clr_ff && (step_ff == clr_idx_ff));
      case (op_ff)
         OP_ADD: begin
            if (!head.valid && !found_ff) begin
               proc_hit   = 1'b1;
               proc.valid = 1'b1;
               proc.fired = 1'b0;
               proc.id    = last_id_ff + 32'd1;
               proc.ivl   = ivl_ff;
               proc.exp   = now_ff + ivl_ff;
               proc.rem   = rep_ff;
               proc.susp  = susp_ff;
            end
         end
         OP_DEL: begin
            if (match) begin
               proc_hit   = 1'b1;
               proc.valid = 1'b0;
            end
         end
         OP_SUSP: begin
            if (match) begin
               proc_hit  = 1'b1;
               proc.susp = 1'b1;
            end
         end
         OP_RES: begin
            if (match) begin
               proc_hit  = 1'b1;
               proc.susp = 1'b0;
               proc.exp  = now_ff + head.ivl;
            end
         end
         OP_TICK: begin
            if (state_ff == ST_SCAN) begin
               proc.fired = due;
               if (due) begin
                  proc.exp = now_ff + head.ivl;
                  if (head.rem != 32'd0) begin
                     proc.rem = head.rem - 32'd1;
                  end
               end
               if (head.valid && (proc.rem == 32'd0)) begin
                  proc.valid = 1'b0;
               end
            end else begin
               proc.fired = sort_fired;
            end
         end
         default: begin
         end
      endcase
      min_take  = (op_ff == OP_TICK) && head.valid && !head.susp && (proc.exp < minexp_ff);
      sort_take = sort_fired && (!best_ff || (head.id > best_id_ff));
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = ((state_ff == ST_FIRE) || (state_ff == ST_RESP)) && out_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign eff_min    = (csr_valid && csr_ready) ? csr_data : min_ivl_ff;
   assign nf_in      = nf_ff + CW'(due);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_id_ff   <= 32'd0;
         min_ivl_ff   <= MIN_IVL_RESET;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         best_ff      <= 1'b0;
         clr_ff       <= 1'b0;
         nf_ff        <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  min_ivl_ff <= csr_data;
               end
               if (req_tvalid) begin
                  op_ff     <= req_tuser;
                  eid_ff    <= req_tdata[31:0];
                  ivl_ff    <= (req_tdata[63:32] < eff_min) ? eff_min : req_tdata[63:32];
                  rep_ff    <= req_tdata[95:64];
                  susp_ff   <= req_tdata[96];
                  now_ff    <= req_tdata[128:97];
                  minexp_ff <= ALL_ONES;
                  found_ff  <= 1'b0;
                  best_ff   <= 1'b0;
                  clr_ff    <= 1'b0;
                  nf_ff     <= '0;
                  step_ff   <= '0;
                  if (req_tuser > OP_TICK) begin
                     res_kind_ff <= KIND_OPDONE;
                     res_id_ff   <= 32'd0;
                     state_ff    <= ST_RESP;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               step_ff <= (step_ff == LAST_STEP) ? '0 : step_ff + IW'(1);
               if (proc_hit) begin
                  found_ff <= 1'b1;
               end
               if (min_take) begin
                  minexp_ff <= proc.exp;
               end
               if (op_ff == OP_TICK) begin
                  nf_ff <= nf_in;
               end
               if (step_ff == LAST_STEP) begin
                  case (op_ff)
                     OP_ADD: begin
                        state_ff <= ST_RESP;
                        if (found_ff || proc_hit) begin
                           res_kind_ff <= KIND_ADDED;
                           res_id_ff   <= last_id_ff + 32'd1;
                           last_id_ff  <= last_id_ff + 32'd1;
                        end else begin
                           res_kind_ff <= KIND_FULL;
                           res_id_ff   <= 32'd0;
                        end
                     end
                     OP_TICK: begin
                        res_kind_ff <= KIND_TICK;
                        res_id_ff   <= 32'd0;
                        state_ff    <= (nf_in != '0) ? ST_SORT : ST_RESP;
                     end
                     default: begin
                        res_kind_ff <= KIND_OPDONE;
                        res_id_ff   <= 32'd0;
                        state_ff    <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_SORT: begin
               step_ff <= (step_ff == LAST_STEP) ? '0 : step_ff + IW'(1);
               if (sort_take) begin
                  best_ff     <= 1'b1;
                  best_id_ff  <= head.id;
                  best_idx_ff <= step_ff;
               end
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_FIRE;
               end
            end
            ST_FIRE: begin
               if (out_free) begin
                  rsp_kind_ff  <= KIND_FIRED;
                  rsp_id_ff    <= best_id_ff;
                  rsp_wait_ff  <= 32'd0;
                  rsp_last_ff  <= 1'b0;
                  nf_ff        <= nf_ff - CW'(1);
                  clr_ff       <= 1'b1;
                  clr_idx_ff   <= best_idx_ff;
                  best_ff      <= 1'b0;
                  state_ff     <= (nf_ff == CW'(1)) ? ST_RESP : ST_SORT;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_kind_ff  <= res_kind_ff;
                  rsp_id_ff    <= res_id_ff;
                  rsp_wait_ff  <= ((res_kind_ff == KIND_TICK) && (minexp_ff > now_ff)) ?
                                  (minexp_ff - now_ff) : 32'd0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_wait_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PTT_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, !req_tready)
   `PTT_ASSERT_IMP(a_fired_not_last, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_FIRED), !rsp_tlast)
   `PTT_ASSERT_IMP(a_sort_has_work, clock, reset, state_ff == ST_SORT, nf_ff != '0)
endmodule
`default_nettype wire

// ===== sv/ptt_cell.sv =====
// One timer slot of the rotating row of cells.
// Depends on ptt_pkg.
`default_nettype none
module ptt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire ptt_pkg::slot_type d,
   output ptt_pkg::slot_type      q
);
   import ptt_pkg::*;

   logic     valid_ff;
   logic     fired_ff;
   slot_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fired_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
         fired_ff <= d.fired;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
      q.fired = fired_ff;
   end
endmodule
`default_nettype wire

// ===== sim/periodic_task_timer_table_tb.sv =====
// Self-checking testbench for the periodic task timer table.
// A predictor in this file tracks the table state; needs ptt_pkg and the top level.
// Covers add, delete, suspend, resume, tick, unused opcodes, table full and min_interval.
`timescale 1ns / 100ps
module periodic_task_timer_table_tb;
   import ptt_pkg::*;

   localparam int NSLOT = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] id;
      logic [31:0] wt;
      logic        last;
   } timer_event_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   periodic_task_timer_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predicted table state
   logic        tv [NSLOT];
   logic        tsusp [NSLOT];
   logic [31:0] tid [NSLOT];
   logic [31:0] tivl [NSLOT];
   logic [31:0] texp [NSLOT];
   logic [31:0] trem [NSLOT];
   logic [31:0] issued_id;
   logic [31:0] min_ivl;

   timer_event_type timer_events_q[$];
   int errors = 0;
   int reqs_sent = 0;
   int events_seen = 0;
   int fired_seen = 0;
   int idle_cycles = 0;
   int ready_mode = 0;
   logic [31:0] cur_now = 0;

   function automatic void push_event(logic [2:0] k, logic [31:0] id, logic [31:0] wt,
                                      logic last);
      timer_event_type e;
      e.kind = k; e.id = id; e.wt = wt; e.last = last;
      timer_events_q = {timer_events_q, e};
   endfunction

   function automatic void timer_table_apply(logic [2:0] op, logic [31:0] eid,
         logic [31:0] ivl, logic [31:0] rep, logic susp, logic [31:0] now);
      logic fired [NSLOT];
      logic [31:0] nxt;
      int i, s, best, nf;
      nxt = ALL_ONES;
      nf = 0;
      if (op == OP_ADD) begin
         s = -1;
         for (i = NSLOT - 1; i >= 0; i--)
            if (!tv[i]) s = i;
         if (s < 0) begin
            push_event(KIND_FULL, 0, 0, 1);
         end else begin
            if (ivl < min_ivl) ivl = min_ivl;
            issued_id = issued_id + 1;
            tv[s] = 1; tid[s] = issued_id; tivl[s] = ivl;
            texp[s] = now + ivl; trem[s] = rep; tsusp[s] = susp;
            push_event(KIND_ADDED, issued_id, 0, 1);
         end
      end else if (op == OP_DEL || op == OP_SUSP || op == OP_RES) begin
         s = -1;
         for (i = NSLOT - 1; i >= 0; i--)
            if (tv[i] && tid[i] == eid) s = i;
         if (s >= 0) begin
            if (op == OP_DEL) tv[s] = 0;
            else if (op == OP_SUSP) tsusp[s] = 1;
            else begin
               tsusp[s] = 0;
               texp[s] = now + tivl[s];
            end
         end
         push_event(KIND_OPDONE, 0, 0, 1);
      end else if (op == OP_TICK) begin
         for (i = 0; i < NSLOT; i++) begin
            fired[i] = 0;
            if (tv[i]) begin
               if (!tsusp[i] && now >= texp[i]) begin
                  fired[i] = 1;
                  nf++;
                  texp[i] = now + tivl[i];
                  if (trem[i] != 0) trem[i] = trem[i] - 1;
               end
               if (!tsusp[i] && nxt > texp[i]) nxt = texp[i];
               if (trem[i] == 0) tv[i] = 0;
            end
         end
         while (nf > 0) begin
            best = -1;
            for (i = 0; i < NSLOT; i++)
               if (fired[i] && (best < 0 || tid[i] > tid[best])) best = i;
            fired[best] = 0;
            push_event(KIND_FIRED, tid[best], 0, 0);
            nf--;
         end
         push_event(KIND_TICK, 0, (nxt > now) ? nxt - now : 32'd0, 1);
      end else begin
         push_event(KIND_OPDONE, 0, 0, 1);
      end
   endfunction

   // sender: optional gap, then hold the request until accepted
   task automatic send_req(logic [2:0] op, logic [31:0] eid, logic [31:0] ivl,
                           logic [31:0] rep, logic susp, logic [31:0] now, int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {7'd0, now, susp, rep, ivl, eid};
      do @(posedge clock); while (!req_tready);
      timer_table_apply(op, eid, ivl, rep, susp, now);
      reqs_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (timer_events_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_min_interval(logic [31:0] v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      min_ivl = v;
   endtask

   function automatic int burst_gap();
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 12);
      return 0;
   endfunction

   function automatic logic [31:0] pick_id();
      int i, s;
      s = -1;
      for (i = 0; i < 4; i++) begin
         s = $urandom_range(0, NSLOT - 1);
         if (tv[s]) return tid[s];
      end
      return issued_id - $urandom_range(0, 3);
   endfunction

   // checker
   always @(posedge clock) begin
      timer_event_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         events_seen++;
         if (timer_events_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d id=%h wait=%h last=%b",
                     $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast);
            errors++;
         end else begin
            e = timer_events_q.pop_front();
            if (e.kind == KIND_FIRED) fired_seen++;
            if (rsp_tuser !== e.kind || rsp_tdata[31:0] !== e.id ||
                rsp_tdata[63:32] !== e.wt || rsp_tlast !== e.last) begin
               $display("%0t: mismatch expected kind=%0d id=%h wait=%h last=%b",
                        $time, e.kind, e.id, e.wt, e.last);
               $display("%0t:          actual   kind=%0d id=%h wait=%h last=%b",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("periodic_task_timer_table_tb NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      send_req(OP_ADD, 0, 0, 3, 0, 0, 0);
      send_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 5, 0);
      send_req(OP_ADD, 0, 20, 0, 0, 7, 0);
      send_req(OP_ADD, 0, 15, 2, 1, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 10, 2);
      send_req(OP_SUSP, 1, 0, 0, 0, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 40, 0);
      send_req(OP_RES, 1, 0, 0, 0, 41, 0);
      send_req(OP_RES, 4, 0, 0, 0, 42, 0);
      send_req(OP_DEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      send_req(OP_SUSP, 32'h1234_5678, 0, 0, 0, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 60, 0);
      send_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
      send_req(3'd6, 0, 0, 0, 0, 0, 1);
      send_req(3'd7, 0, 0, 0, 0, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      send_req(OP_DEL, 2, 0, 0, 0, 0, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
   endtask

   task automatic test_table_full();
      int i;
      for (i = 0; i < NSLOT + 2; i++)
         send_req(OP_ADD, 0, $urandom_range(0, 50), $urandom_range(1, 3), i[0], cur_now,
                  burst_gap());
      send_req(OP_TICK, 0, 0, 0, 0, cur_now + 60, 0);
      send_req(OP_TICK, 0, 0, 0, 0, cur_now + 200, 0);
      send_req(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      cur_now = cur_now + 300;
   endtask

   task automatic test_random(int count);
      int i, r;
      logic [2:0]  op;
      logic [31:0] eid, ivl, rep, now;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         eid = 0; ivl = 0; rep = 0;
         cur_now = cur_now + $urandom_range(0, 8);
         now = cur_now;
         if (r < 35) begin
            op = OP_ADD;
            ivl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
            rep = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
            if ($urandom_range(0, 15) == 0) now = $urandom;
         end else if (r < 65) begin
            op = OP_TICK;
            if ($urandom_range(0, 15) == 0) now = $urandom;
         end else if (r < 90) begin
            op = 3'($urandom_range(OP_DEL, OP_RES));
            eid = pick_id();
         end else begin
            op = 3'($urandom_range(0, 7));
            eid = $urandom; ivl = $urandom; rep = $urandom; now = $urandom;
         end
         send_req(op, eid, ivl, rep, 1'($urandom_range(0, 3) == 0), now, burst_gap());
         if ($urandom_range(0, 59) == 0) drain();
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < NSLOT; i++) begin
         tv[i] = 0; tsusp[i] = 0; tid[i] = 0; tivl[i] = 0; texp[i] = 0; trem[i] = 0;
      end
      issued_id = 0;
      min_ivl = MIN_IVL_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_table_full();
      write_min_interval(0);
      test_random(80);
      write_min_interval(32'hFFFF_FFFF);
      test_table_full();
      write_min_interval($urandom_range(1, 30));
      test_random(120);
      write_min_interval(MIN_IVL_RESET);
      test_random(110);
      drain();
      repeat (300) @(posedge clock);
      $display("sent %0d requests, checked %0d results (%0d fired events)",
               reqs_sent, events_seen, fired_seen);
      $display("phases used min_interval 0, all ones, a random value and the reset value");
      if (errors == 0 && timer_events_q.size() == 0)
         $display("periodic_task_timer_table_tb OK");
      else
         $display("periodic_task_timer_table_tb NOT OK");
      $finish;
   end
endmodule
